[sv/grant_element_merge_table_macros.svh]
// ----------------------------------------------------------------------------
// grant element merge table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GRANT_ELEMENT_MERGE_TABLE_MACROS_SVH
`define GRANT_ELEMENT_MERGE_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GEMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GEMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gemt_pkg.sv]
// ----------------------------------------------------------------------------
// gemt_pkg
// types, codes and defaults shared by the grant element merge table
// ----------------------------------------------------------------------------
package gemt_pkg;

    localparam int DEF_TABLE_DEPTH  = 16;
    localparam int DEF_ELEMENT_SIZE = 6;

    // operation codes, any other code reads an entry
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_MERGED_BEFORE = 3'd0;
    localparam logic [2:0] ST_MERGED_AFTER  = 3'd1;
    localparam logic [2:0] ST_PERS_EXTENDED = 3'd2;
    localparam logic [2:0] ST_INSERTED      = 3'd3;
    localparam logic [2:0] ST_DROPPED_FULL  = 3'd4;
    localparam logic [2:0] ST_CLEARED       = 3'd5;
    localparam logic [2:0] ST_READ_OK       = 3'd6;
    localparam logic [2:0] ST_READ_EMPTY    = 3'd7;

    typedef struct packed {
        logic [15:0] node;
        logic [15:0] frame;
        logic [7:0]  start;
        logic [8:0]  range;
        logic [7:0]  persistence;
        logic        from_requester;
        logic [3:0]  channel;
        logic [2:0]  service;
    } grant_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  read_index;
        logic [15:0] grant_node;
        logic [15:0] grant_frame;
        logic [7:0]  grant_start;
        logic [8:0]  grant_range;
        logic [7:0]  grant_persistence;
        logic        grant_from_requester;
        logic [3:0]  grant_channel;
        logic [2:0]  grant_service;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [15:0] entry_node;
        logic [15:0] entry_frame;
        logic [7:0]  entry_start;
        logic [8:0]  entry_range;
        logic [7:0]  entry_persistence;
        logic        entry_from_requester;
        logic [3:0]  entry_channel;
        logic [2:0]  entry_service;
        logic [4:0]  entry_count;
        logic [15:0] message_length;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic read_issue;
        logic walk_start;
        logic walk_step;
        logic commit;
        logic finish;
        logic read_result;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_add;
        logic op_clear;
        logic count_zero;
        logic last_cmp;
        logic hit;
    } dp_stat_t;

endpackage

[sv/gemt_if.sv]
// ----------------------------------------------------------------------------
// gemt channel interfaces
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface gemt_cmd_if;
    import gemt_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gemt_rsp_if;
    import gemt_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/gemt_ctrl.sv]
// ----------------------------------------------------------------------------
// gemt_ctrl
// sequencer for the table walk, insertion, clear and read operations
// ----------------------------------------------------------------------------
module gemt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_ready,
    input  gemt_pkg::dp_stat_t stat,
    output gemt_pkg::dp_cmd_t  cmd,
    output logic               in_ready,
    output logic               out_valid
);
    import gemt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_FINISH,
        S_READ,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   valid_reg;
    logic   valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        valid_next = valid_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op_clear)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_HOLD;
                end
                else if (!stat.op_add)
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = S_READ;
                end
                else if (stat.count_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.hit)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_HOLD;
                end
                else if (stat.last_cmp)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_HOLD;
            end
            S_READ:
            begin
                cmd.read_result = 1'b1;
                state_next      = S_HOLD;
            end
            S_HOLD:
            begin
                // wait for the output slot to free up
                if (!valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                ready_next = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ready_reg;
    assign out_valid = valid_reg;

endmodule

[sv/gemt_dp.sv]
// ----------------------------------------------------------------------------
// gemt_dp
// table memory, circular head pointer, match logic and result registers
// ----------------------------------------------------------------------------
module gemt_dp #(
    parameter int TABLE_DEPTH  = gemt_pkg::DEF_TABLE_DEPTH,
    parameter int ELEMENT_SIZE = gemt_pkg::DEF_ELEMENT_SIZE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  gemt_pkg::in_item_t  in_data,
    input  gemt_pkg::dp_cmd_t   cmd,
    output gemt_pkg::dp_stat_t  stat,
    output gemt_pkg::out_item_t out_data
);
    import gemt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [IW:0]   DEPTH_P = (IW + 1)'(TABLE_DEPTH);
    localparam logic [15:0]   ELEM_C  = 16'(ELEMENT_SIZE);

    // logical position to physical row, newest entry sits at head
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd,
                                           input logic [IW-1:0] ix);
        logic [IW:0] s;
        begin
            s = {1'b0, hd} + {1'b0, ix};
            if (s >= DEPTH_P)
            begin
                s = s - DEPTH_P;
            end
            return s[IW-1:0];
        end
    endfunction

    function automatic out_item_t make_res(input logic [2:0]  st,
                                           input logic [3:0]  slot,
                                           input grant_t      en,
                                           input logic [4:0]  cnt,
                                           input logic [15:0] len);
        out_item_t r;
        begin
            r.status               = st;
            r.slot_index           = slot;
            r.entry_node           = en.node;
            r.entry_frame          = en.frame;
            r.entry_start          = en.start;
            r.entry_range          = en.range;
            r.entry_persistence    = en.persistence;
            r.entry_from_requester = en.from_requester;
            r.entry_channel        = en.channel;
            r.entry_service        = en.service;
            r.entry_count          = cnt;
            r.message_length       = len;
            return r;
        end
    endfunction

    grant_t        mem [TABLE_DEPTH];

    logic [15:0]   base_reg;
    in_item_t      item_reg;
    grant_t        rd_data_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic [IW-1:0] cmp_addr_reg;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [15:0]   length_reg;
    logic [15:0]   length_next;
    out_item_t     res_reg;
    out_item_t     res_next;
    out_item_t     out_reg;

    grant_t        g;
    grant_t        e;
    grant_t        upd;
    logic          same_cls;
    logic          same_fp;
    logic          hit_before;
    logic          hit_after;
    logic          hit_ext;
    logic [9:0]    range_sum;
    logic [8:0]    range_sat;
    logic [7:0]    pers_inc;
    logic [2:0]    hit_status;
    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] rd_addr;
    logic          read_ok;
    logic [IW-1:0] head_dec;
    logic [CW-1:0] count_inc;
    logic [15:0]   length_inc;
    logic          full;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    grant_t        mem_wdata;

    assign g.node           = item_reg.grant_node;
    assign g.frame          = item_reg.grant_frame;
    assign g.start          = item_reg.grant_start;
    assign g.range          = item_reg.grant_range;
    assign g.persistence    = item_reg.grant_persistence;
    assign g.from_requester = item_reg.grant_from_requester;
    assign g.channel        = item_reg.grant_channel;
    assign g.service        = item_reg.grant_service;
    assign e = rd_data_reg;

    // match tests against the entry under compare
    always_comb
    begin
        same_cls = (g.node == e.node) && (g.from_requester == e.from_requester) &&
                   (g.channel == e.channel) && (g.service == e.service);
        same_fp  = (g.frame == e.frame) && (g.persistence == e.persistence);
        hit_before = same_cls && same_fp &&
                     ((10'(g.start) + 10'(g.range)) == 10'(e.start));
        hit_after  = same_cls && same_fp &&
                     ((10'(e.start) + 10'(e.range)) == 10'(g.start));
        hit_ext    = same_cls && (g.start == e.start) && (g.range == e.range) &&
                     (g.frame == 16'(e.frame + 16'(e.persistence)));
        range_sum  = 10'(g.range) + 10'(e.range);
        range_sat  = range_sum[9] ? 9'h1FF : range_sum[8:0];
        pers_inc   = (e.persistence == 8'hFF) ? 8'hFF : e.persistence + 8'd1;
        upd        = e;
        if (hit_before)
        begin
            upd.start  = g.start;
            upd.range  = range_sat;
            hit_status = ST_MERGED_BEFORE;
        end
        else if (hit_after)
        begin
            upd.range  = range_sat;
            hit_status = ST_MERGED_AFTER;
        end
        else
        begin
            upd.persistence = pers_inc;
            hit_status      = ST_PERS_EXTENDED;
        end
    end

    // read port address
    always_comb
    begin
        rd_en  = cmd.walk_start || cmd.walk_step || cmd.read_issue;
        rd_idx = '0;
        if (cmd.walk_step)
        begin
            rd_idx = cmp_idx_reg + IW'(1);
        end
        else if (cmd.read_issue)
        begin
            rd_idx = IW'(item_reg.read_index);
        end
        rd_addr = phys(head_reg, rd_idx);
    end

    assign read_ok    = 32'(item_reg.read_index) < 32'(count_reg);
    assign head_dec   = (head_reg == '0) ? IW'(TABLE_DEPTH - 1) : head_reg - IW'(1);
    assign count_inc  = count_reg + CW'(1);
    assign length_inc = length_reg + ELEM_C;
    assign full       = (count_reg == DEPTH_C);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        length_next = length_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        mem_waddr   = cmp_addr_reg;
        mem_wdata   = upd;
        if (cmd.clear)
        begin
            count_next  = '0;
            length_next = base_reg;
            res_next    = make_res(ST_CLEARED, 4'd0, '0, 5'd0, base_reg);
        end
        if (cmd.commit)
        begin
            mem_we   = 1'b1;
            res_next = make_res(hit_status, 4'(cmp_idx_reg), upd, 5'(count_reg),
                                length_reg);
        end
        if (cmd.finish)
        begin
            if (full)
            begin
                res_next = make_res(ST_DROPPED_FULL, 4'd0, g, 5'(count_reg),
                                    length_reg);
            end
            else
            begin
                mem_we      = 1'b1;
                mem_waddr   = head_dec;
                mem_wdata   = g;
                head_next   = head_dec;
                count_next  = count_inc;
                length_next = length_inc;
                res_next    = make_res(ST_INSERTED, 4'd0, g, 5'(count_inc), length_inc);
            end
        end
        if (cmd.read_result)
        begin
            if (read_ok)
            begin
                res_next = make_res(ST_READ_OK, item_reg.read_index, e,
                                    5'(count_reg), length_reg);
            end
            else
            begin
                res_next = make_res(ST_READ_EMPTY, item_reg.read_index, '0,
                                    5'(count_reg), length_reg);
            end
        end
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            cmp_idx_reg  <= rd_idx;
            cmp_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        res_reg <= res_next;
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            length_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            head_reg   <= head_next;
            count_reg  <= count_next;
            length_reg <= length_next;
        end
    end

    assign stat.op_add     = (item_reg.op == OP_ADD);
    assign stat.op_clear   = (item_reg.op == OP_CLEAR);
    assign stat.count_zero = (count_reg == '0);
    assign stat.last_cmp   = (CW'(cmp_idx_reg) == (count_reg - CW'(1)));
    assign stat.hit        = hit_before || hit_after || hit_ext;
    assign out_data        = out_reg;

endmodule

[sv/grant_element_merge_table.sv]
// ----------------------------------------------------------------------------
// grant_element_merge_table
// add: result after a hit at the k-th entry, or after the whole walk on insert or drop
// clear and read skip the walk; the walk compares one table entry per cycle
// one item in flight; the next item is taken the cycle after its result is registered
// reset clears entry count, message length and base_length; table rows are not swept
// ----------------------------------------------------------------------------
module grant_element_merge_table #(
    parameter int TABLE_DEPTH  = gemt_pkg::DEF_TABLE_DEPTH,
    parameter int ELEMENT_SIZE = gemt_pkg::DEF_ELEMENT_SIZE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    gemt_cmd_if.sink    cmd,
    gemt_rsp_if.source  result
);
    import gemt_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer: dispatch on op, walk the table newest first, merge or extend
    // on a hit, else insert or drop, and park the result in the output register
    gemt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .out_ready (result.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd),
        .in_ready  (cmd.ready),
        .out_valid (result.valid)
    );

    // datapath: table held as a circular buffer so a front insert is a
    // head pointer decrement instead of a shift of every row
    gemt_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .ELEMENT_SIZE (ELEMENT_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (cmd.data),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .out_data  (result.data)
    );

endmodule

[sv/gemt_check.sv]
// ----------------------------------------------------------------------------
// gemt_check
// port level checks for the grant element merge table
// ----------------------------------------------------------------------------
`include "grant_element_merge_table_macros.svh"

module gemt_check (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                result_valid,
    input logic                result_ready,
    input gemt_pkg::out_item_t result_data
);
    import gemt_pkg::*;

    // stalled result holds
    `GEMT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data), "result changed while stalled")

    // one item at a time: busy right after an accept
    `GEMT_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "item accepted while busy")

    // clear empties the table and zeroes the entry
    `GEMT_ASSERT_NOW(a_clear_result, result_valid && result_data.status == ST_CLEARED, result_data.entry_count == 5'd0 && result_data.slot_index == 4'd0 && result_data.entry_node == 16'd0, "bad clear result")

    // insert and drop always report the front position
    `GEMT_ASSERT_NOW(a_front_slot, result_valid && (result_data.status == ST_INSERTED || result_data.status == ST_DROPPED_FULL), result_data.slot_index == 4'd0, "insert or drop not at front")

    // an empty read shows a zero entry
    `GEMT_ASSERT_NOW(a_read_empty, result_valid && result_data.status == ST_READ_EMPTY, result_data.entry_range == 9'd0 && result_data.entry_persistence == 8'd0 && result_data.entry_node == 16'd0, "empty read not zero")

endmodule

bind grant_element_merge_table gemt_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

[verif/tb_grant_element_merge_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grant_element_merge_table
// drives grant, clear and read commands into the merge table, predicts
// every result from a shadow copy of the table and checks it field by field
// ----------------------------------------------------------------------------
module tb_grant_element_merge_table;
    import gemt_pkg::*;

    localparam int DEPTH         = DEF_TABLE_DEPTH;
    localparam int ELEM_LEN      = DEF_ELEMENT_SIZE;
    // settle wait, long enough for a full walk plus insert
    localparam int SETTLE_CYCLES = DEF_TABLE_DEPTH + 8;
    localparam int MAX_PRINTED   = 40;

    // unused op code, the block decodes it as a read
    localparam logic [1:0] OP_SPARE = 2'd3;

    // flavors of generated grant, each aimed at one table entry
    localparam int GEN_MERGE_LO  = 0;
    localparam int GEN_MERGE_HI  = 1;
    localparam int GEN_EXTEND    = 2;
    localparam int GEN_NEAR_MISS = 3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    gemt_cmd_if cmd_ch();
    gemt_rsp_if rsp_ch();

    grant_element_merge_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .result    (rsp_ch)
    );

    // shadow of the block state, newest grant at position 0
    grant_t      shadow_tbl [DEPTH];
    int unsigned shadow_count = 0;
    logic [15:0] shadow_len   = 16'd0;
    logic [15:0] shadow_base  = 16'd0;

    // predicted results, oldest first
    out_item_t   pending_results [$];

    int unsigned mismatches = 0;
    int unsigned cmds_sent  = 0;
    int unsigned status_hits [8];

    // idle and stall odds in percent, changed per phase
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    // free running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // packs one result, count and length taken after the update
    function automatic out_item_t entry_result(input logic [2:0] st,
                                               input logic [3:0] slot,
                                               input grant_t g);
        out_item_t r;
        r.status               = st;
        r.slot_index           = slot;
        r.entry_node           = g.node;
        r.entry_frame          = g.frame;
        r.entry_start          = g.start;
        r.entry_range          = g.range;
        r.entry_persistence    = g.persistence;
        r.entry_from_requester = g.from_requester;
        r.entry_channel        = g.channel;
        r.entry_service        = g.service;
        r.entry_count          = 5'(shadow_count);
        r.message_length       = shadow_len;
        return r;
    endfunction

    // merged range, saturating at the 9-bit ceiling
    function automatic logic [8:0] joined_range(input logic [8:0] a, input logic [8:0] b);
        logic [9:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > 10'd511) ? 9'd511 : sum[8:0];
    endfunction

    // applies one accepted command to the shadow table, returns its result
    function automatic out_item_t predict_command(input in_item_t it);
        grant_t      g;
        grant_t      e;
        logic [15:0] follow_frame;
        logic        same_class;
        int          i;
        g.node           = it.grant_node;
        g.frame          = it.grant_frame;
        g.start          = it.grant_start;
        g.range          = it.grant_range;
        g.persistence    = it.grant_persistence;
        g.from_requester = it.grant_from_requester;
        g.channel        = it.grant_channel;
        g.service        = it.grant_service;

        if (it.op == OP_CLEAR)
        begin
            shadow_count = 0;
            shadow_len   = shadow_base;
            return entry_result(ST_CLEARED, 4'd0, '0);
        end

        // every other non-add code reads
        if (it.op != OP_ADD)
        begin
            if (it.read_index < shadow_count)
                return entry_result(ST_READ_OK, it.read_index, shadow_tbl[it.read_index]);
            return entry_result(ST_READ_EMPTY, it.read_index, '0);
        end

        // walk from the newest entry, first qualifying entry wins
        for (i = 0; i < shadow_count; i++)
        begin
            e = shadow_tbl[i];
            same_class = g.node == e.node && g.from_requester == e.from_requester &&
                         g.channel == e.channel && g.service == e.service;
            if (same_class && g.frame == e.frame && g.persistence == e.persistence)
            begin
                // contiguity sums are taken wide, no wrap at 256
                if (int'(g.start) + int'(g.range) == int'(e.start))
                begin
                    e.start = g.start;
                    e.range = joined_range(g.range, e.range);
                    shadow_tbl[i] = e;
                    return entry_result(ST_MERGED_BEFORE, 4'(i), e);
                end
                if (int'(e.start) + int'(e.range) == int'(g.start))
                begin
                    e.range = joined_range(g.range, e.range);
                    shadow_tbl[i] = e;
                    return entry_result(ST_MERGED_AFTER, 4'(i), e);
                end
            end
            // frame span end wraps at 16 bits
            follow_frame = e.frame + {8'd0, e.persistence};
            if (same_class && g.start == e.start && g.range == e.range &&
                g.frame == follow_frame)
            begin
                if (e.persistence != 8'hFF)
                    e.persistence = e.persistence + 8'd1;
                shadow_tbl[i] = e;
                return entry_result(ST_PERS_EXTENDED, 4'(i), e);
            end
        end

        // no match and no room: grant is echoed back, state untouched
        if (shadow_count >= DEPTH)
            return entry_result(ST_DROPPED_FULL, 4'd0, g);

        for (i = shadow_count; i > 0; i--)
            shadow_tbl[i] = shadow_tbl[i - 1];
        shadow_tbl[0] = g;
        shadow_count++;
        shadow_len = shadow_len + 16'(ELEM_LEN);
        return entry_result(ST_INSERTED, 4'd0, g);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            note_mismatch("result item with no command outstanding");
            return;
        end
        want = pending_results.pop_front();
        status_hits[want.status]++;
        compare_field("status",         16'(got.status),         16'(want.status));
        compare_field("slot_index",     16'(got.slot_index),     16'(want.slot_index));
        compare_field("entry_node",     got.entry_node,          want.entry_node);
        compare_field("entry_frame",    got.entry_frame,         want.entry_frame);
        compare_field("entry_start",    16'(got.entry_start),    16'(want.entry_start));
        compare_field("entry_range",    16'(got.entry_range),    16'(want.entry_range));
        compare_field("entry_pers",     16'(got.entry_persistence),
                      16'(want.entry_persistence));
        compare_field("entry_from_req", 16'(got.entry_from_requester),
                      16'(want.entry_from_requester));
        compare_field("entry_channel",  16'(got.entry_channel),  16'(want.entry_channel));
        compare_field("entry_service",  16'(got.entry_service),  16'(want.entry_service));
        compare_field("entry_count",    16'(got.entry_count),    16'(want.entry_count));
        compare_field("message_length", got.message_length,      want.message_length);
    endtask

    // values sampled at the edge are the ones settled before it
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_result(rsp_ch.data);
    end

    // receiver back-pressure, odds set per phase
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offers one item, random gaps first, predicts on acceptance;
    // valid stays high into the next item when no gap is drawn
    task automatic send_command(input in_item_t it);
        out_item_t want;
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        want = predict_command(it);
        pending_results = {pending_results, want};
        cmds_sent++;
    endtask

    // random filler for the fields an op ignores
    function automatic in_item_t noisy_command(input logic [1:0] op);
        logic [95:0] noise;
        in_item_t    it;
        noise = {$urandom, $urandom, $urandom};
        it    = noise[$bits(in_item_t)-1:0];
        it.op = op;
        return it;
    endfunction

    function automatic grant_t mk_grant(input logic [15:0] node, input logic [15:0] frame,
                                        input logic [7:0] start, input logic [8:0] span,
                                        input logic [7:0] pers, input logic req,
                                        input logic [3:0] chan, input logic [2:0] svc);
        grant_t g;
        g.node           = node;
        g.frame          = frame;
        g.start          = start;
        g.range          = span;
        g.persistence    = pers;
        g.from_requester = req;
        g.channel        = chan;
        g.service        = svc;
        return g;
    endfunction

    task automatic send_add(input grant_t g);
        in_item_t it;
        it = noisy_command(OP_ADD);
        it.grant_node           = g.node;
        it.grant_frame          = g.frame;
        it.grant_start          = g.start;
        it.grant_range          = g.range;
        it.grant_persistence    = g.persistence;
        it.grant_from_requester = g.from_requester;
        it.grant_channel        = g.channel;
        it.grant_service        = g.service;
        send_command(it);
    endtask

    task automatic send_clear();
        send_command(noisy_command(OP_CLEAR));
    endtask

    task automatic send_read(input logic [1:0] op, input logic [3:0] idx);
        in_item_t it;
        it = noisy_command(op);
        it.read_index = idx;
        send_command(it);
    endtask

    // drops valid and waits out every outstanding result plus a walk
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // base_length is only written with nothing in flight
    task automatic write_base_length(input logic [15:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_base = value;
    endtask

    // mostly grants aimed at a live entry so merges, extensions and near misses
    // happen, the rest fresh grants
    function automatic grant_t random_grant();
        grant_t g;
        grant_t e;
        int     kind;
        g.node = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
        g.frame          = 16'($urandom);
        g.start          = 8'($urandom);
        g.range          = 9'($urandom);
        g.persistence    = 8'($urandom);
        g.from_requester = 1'($urandom);
        g.channel        = 4'($urandom);
        g.service        = 3'($urandom);
        if (shadow_count == 0 || $urandom_range(99) < 30)
            return g;

        e    = shadow_tbl[$urandom_range(shadow_count - 1)];
        kind = $urandom_range(GEN_NEAR_MISS, GEN_MERGE_LO);
        g.node           = e.node;
        g.from_requester = e.from_requester;
        g.channel        = e.channel;
        g.service        = e.service;
        // an entry ending past 255 cannot take a grant behind it
        if (kind == GEN_EXTEND ||
            (kind == GEN_MERGE_HI && int'(e.start) + int'(e.range) > 255))
        begin
            g.start = e.start;
            g.range = e.range;
            g.frame = e.frame + {8'd0, e.persistence};
        end
        else
        begin
            g.frame       = e.frame;
            g.persistence = e.persistence;
            if (kind == GEN_MERGE_HI)
                g.start = e.start + e.range[7:0];
            else
            begin
                g.range = 9'($urandom_range(e.start));
                g.start = e.start - g.range[7:0];
            end
        end

        // near miss: one bit off in a field the match depends on
        if (kind == GEN_NEAR_MISS)
        begin
            case ($urandom_range(5))
                0:       g.node        = g.node ^ (16'd1 << $urandom_range(15));
                1:       g.frame       = g.frame ^ (16'd1 << $urandom_range(15));
                2:       g.persistence = g.persistence ^ (8'd1 << $urandom_range(7));
                3:       g.channel     = g.channel ^ (4'd1 << $urandom_range(3));
                4:       g.service     = g.service ^ (3'd1 << $urandom_range(2));
                default: g.from_requester = ~g.from_requester;
            endcase
        end
        return g;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // clear loads a near-wrap length, read of an empty table
    task automatic test_clear_and_empty_read();
        write_base_length(16'hFFFC);
        send_clear();
        send_read(OP_READ, 4'd0);
    endtask

    // insert wraps the length, merge ahead saturates the range,
    // extension finds a frame span that wraps past 65535
    task automatic test_merge_and_extend();
        send_add(mk_grant(16'h1234, 16'hFFF0, 8'd200, 9'd400, 8'h20, 1'b1, 4'hF, 3'h7));
        send_add(mk_grant(16'h1234, 16'hFFF0, 8'd0, 9'd200, 8'h20, 1'b1, 4'hF, 3'h7));
        send_add(mk_grant(16'h1234, 16'h0010, 8'd0, 9'd511, 8'h05, 1'b1, 4'hF, 3'h7));
    endtask

    // an entry ending at 260 must not touch a grant at 4,
    // persistence held at 255, then a merge behind the newest entry
    task automatic test_contiguity_edges();
        send_add(mk_grant(16'hFFFF, 16'd0, 8'd250, 9'd10, 8'd255, 1'b0, 4'h0, 3'h0));
        send_add(mk_grant(16'hFFFF, 16'd0, 8'd4, 9'd3, 8'd255, 1'b0, 4'h0, 3'h0));
        send_add(mk_grant(16'hFFFF, 16'd255, 8'd250, 9'd10, 8'd0, 1'b0, 4'h0, 3'h0));
        send_add(mk_grant(16'hFFFF, 16'd0, 8'd7, 9'd5, 8'd255, 1'b0, 4'h0, 3'h0));
    endtask

    // spare op code reads, read past the valid entries
    task automatic test_reads();
        send_read(OP_SPARE, 4'd1);
        send_read(OP_READ, 4'd15);
    endtask

    // fill with unrelated grants, one more is dropped, read the oldest
    task automatic test_table_full();
        int i;
        for (i = 0; shadow_count < DEPTH; i++)
            send_add(mk_grant(16'h0100 + 16'(i), 16'(i * 300), 8'(i * 16), 9'd5,
                              8'd1, 1'(i), 4'(i), 3'(i)));
        send_add(mk_grant(16'hABCD, 16'h5555, 8'd17, 9'd33, 8'd9, 1'b1, 4'h5, 3'h2));
        send_read(OP_READ, 4'(DEPTH - 1));
    endtask

    // one phase of mixed traffic under given idle and stall odds
    task automatic test_random_traffic(input int n, input int src_pct, input int snk_pct,
                                       input logic [15:0] base);
        int roll;
        int k;
        write_base_length(base);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        send_clear();
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                send_clear();
            else if (roll < 16)
                send_read(($urandom_range(3) == 0) ? OP_SPARE : OP_READ,
                          4'($urandom_range(15)));
            else
                send_add(random_grant());
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= 16'd0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clear_and_empty_read();
        test_merge_and_extend();
        test_contiguity_edges();
        test_reads();
        test_table_full();

        test_random_traffic(450, 0, 0, 16'h0000);
        test_random_traffic(450, 85, 0, 16'hFFFF);
        test_random_traffic(450, 0, 85, 16'($urandom));
        test_random_traffic(450, 26, 26, 16'hFFFA);

        // drain and give the block time to show any stray result
        wait_idle();
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("ran %0d commands: %0d merged ahead, %0d merged behind, %0d extended,",
                 cmds_sent, status_hits[ST_MERGED_BEFORE], status_hits[ST_MERGED_AFTER],
                 status_hits[ST_PERS_EXTENDED]);
        $display("  %0d inserted, %0d dropped, %0d clears, %0d reads hit, %0d reads empty",
                 status_hits[ST_INSERTED], status_hits[ST_DROPPED_FULL],
                 status_hits[ST_CLEARED], status_hits[ST_READ_OK], status_hits[ST_READ_EMPTY]);
        if (mismatches == 0)
            $display("tb_grant_element_merge_table: clean");
        else
            $display("tb_grant_element_merge_table: errors");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("tb_grant_element_merge_table: errors");
        $finish;
    end

endmodule
